// File: rtl/core/oar_pkg.sv
package oar_pkg;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ACC   = 2'd2;
    localparam logic [1:0] KIND_ADDR  = 2'd3;

    localparam logic [7:0]  PTR_LAST_IN_PAGE = 8'hff;
    localparam logic [15:0] PAGE_MASK        = 16'hff00;
    localparam int          QUEUE_DEPTH      = 2;

    typedef enum logic [3:0] {
        MODE_IMP = 4'd0,
        MODE_ACC = 4'd1,
        MODE_IMM = 4'd2,
        MODE_ZP  = 4'd3,
        MODE_ZPX = 4'd4,
        MODE_ZPY = 4'd5,
        MODE_IZX = 4'd6,
        MODE_IZY = 4'd7,
        MODE_ABS = 4'd8,
        MODE_ABX = 4'd9,
        MODE_ABY = 4'd10,
        MODE_IND = 4'd11,
        MODE_REL = 4'd12
    } mode_t;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  read_data;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] read_address;
        logic [15:0] operand_value;
        logic [1:0]  operand_bytes;
        logic        page_crossed;
    } out_t;

    // Classified item carried from the front part to the back part
    typedef struct packed {
        logic        is_start;
        mode_t       mode;
        logic [15:0] pc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  data;
    } item_t;

endpackage

// File: rtl/core/oar_front.sv
module oar_front import oar_pkg::*; (
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_item,
    input  logic  q_ready,
    output logic  q_push,
    output item_t q_item
);

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    // Classify: split start from returned byte, fold unused mode codes onto implied
    always_comb
    begin
        q_item.is_start = (in_item.cmd == CMD_START);
        if (in_item.mode > 4'(MODE_REL))
        begin
            q_item.mode = MODE_IMP;
        end
        else
        begin
            q_item.mode = mode_t'(in_item.mode);
        end
        q_item.pc      = in_item.pc;
        q_item.index_x = in_item.index_x;
        q_item.index_y = in_item.index_y;
        q_item.data    = in_item.read_data;
    end

endmodule

// File: rtl/core/oar_queue.sv
module oar_queue import oar_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  ready,
    output logic  valid,
    input  logic  pop,
    output item_t head
);

    item_t      entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign ready = (count_reg != 2'(QUEUE_DEPTH));
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not follow a lone push");

endmodule

// File: rtl/core/oar_back.sv
module oar_back import oar_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_item
);

    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_OP_LO  = 3'd1,
        STEP_OP_HI  = 3'd2,
        STEP_PTR_LO = 3'd3,
        STEP_PTR_HI = 3'd4
    } step_t;

    step_t       step_reg;
    step_t       step_next;
    mode_t       mode_reg;
    mode_t       mode_next;
    logic [15:0] pc_reg;
    logic [15:0] pc_next;
    logic [7:0]  x_reg;
    logic [7:0]  x_next;
    logic [7:0]  y_reg;
    logic [7:0]  y_next;
    logic [7:0]  op_lo_reg;
    logic [7:0]  op_lo_next;
    logic [7:0]  op_hi_reg;
    logic [7:0]  op_hi_next;
    logic [7:0]  ptr_lo_reg;
    logic [7:0]  ptr_lo_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_t        out_item_reg;
    out_t        out_item_next;

    logic        res_valid;
    out_t        res;
    logic [15:0] idx_base;
    logic [7:0]  idx_off;
    logic [15:0] idx_sum;
    logic        idx_crossed;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Shared indexed adder for abx, aby and (zp),Y
    always_comb
    begin
        if (step_reg == STEP_PTR_HI)
        begin
            idx_base = {q_item.data, ptr_lo_reg};
            idx_off  = y_reg;
        end
        else
        begin
            idx_base = {q_item.data, op_lo_reg};
            idx_off  = (mode_reg == MODE_ABX) ? x_reg : y_reg;
        end
        idx_sum     = idx_base + {8'h00, idx_off};
        idx_crossed = (idx_base[15:8] != idx_sum[15:8]);
    end

    always_comb
    begin
        step_next   = step_reg;
        mode_next   = mode_reg;
        pc_next     = pc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        op_lo_next  = op_lo_reg;
        op_hi_next  = op_hi_reg;
        ptr_lo_next = ptr_lo_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (q_pop && q_item.is_start)
        begin
            mode_next = q_item.mode;
            pc_next   = q_item.pc;
            x_next    = q_item.index_x;
            y_next    = q_item.index_y;
            res_valid = 1'b1;
            step_next = STEP_IDLE;
            case (q_item.mode)
                MODE_ACC:
                begin
                    res.kind = KIND_ACC;
                end
                MODE_REL:
                begin
                    res.kind          = KIND_ADDR;
                    res.operand_value = q_item.pc;
                    res.operand_bytes = 2'd1;
                end
                MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_IZX, MODE_IZY,
                MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND:
                begin
                    step_next        = STEP_OP_LO;
                    res.kind         = KIND_READ;
                    res.read_address = q_item.pc;
                end
                default:
                begin
                    res.kind = KIND_VALUE;
                end
            endcase
        end
        else if (q_pop)
        begin
            // A byte that matches nothing ends the sequence quietly
            step_next = STEP_IDLE;
            case (step_reg)
                STEP_OP_LO:
                begin
                    op_lo_next = q_item.data;
                    case (mode_reg)
                        MODE_IMM:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_VALUE;
                            res.operand_value = {8'h00, q_item.data};
                            res.operand_bytes = 2'd1;
                        end
                        MODE_ZP:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = {8'h00, q_item.data};
                            res.operand_bytes = 2'd1;
                        end
                        MODE_ZPX:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = {8'h00, 8'(q_item.data + x_reg)};
                            res.operand_bytes = 2'd1;
                        end
                        MODE_ZPY:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = {8'h00, 8'(q_item.data + y_reg)};
                            res.operand_bytes = 2'd1;
                        end
                        MODE_IZX:
                        begin
                            res_valid        = 1'b1;
                            step_next        = STEP_PTR_LO;
                            res.kind         = KIND_READ;
                            res.read_address = {8'h00, 8'(q_item.data + x_reg)};
                        end
                        MODE_IZY:
                        begin
                            res_valid        = 1'b1;
                            step_next        = STEP_PTR_LO;
                            res.kind         = KIND_READ;
                            res.read_address = {8'h00, q_item.data};
                        end
                        MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND:
                        begin
                            res_valid        = 1'b1;
                            step_next        = STEP_OP_HI;
                            res.kind         = KIND_READ;
                            res.read_address = pc_reg + 16'd1;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                STEP_OP_HI:
                begin
                    op_hi_next = q_item.data;
                    case (mode_reg)
                        MODE_ABS:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = {q_item.data, op_lo_reg};
                            res.operand_bytes = 2'd2;
                        end
                        MODE_ABX, MODE_ABY:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = idx_sum;
                            res.operand_bytes = 2'd2;
                            res.page_crossed  = idx_crossed;
                        end
                        MODE_IND:
                        begin
                            res_valid        = 1'b1;
                            step_next        = STEP_PTR_LO;
                            res.kind         = KIND_READ;
                            res.read_address = {q_item.data, op_lo_reg};
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                STEP_PTR_LO:
                begin
                    ptr_lo_next = q_item.data;
                    case (mode_reg)
                        MODE_IZX:
                        begin
                            res_valid        = 1'b1;
                            step_next        = STEP_PTR_HI;
                            res.kind         = KIND_READ;
                            res.read_address = {8'h00, 8'(op_lo_reg + x_reg + 8'd1)};
                        end
                        MODE_IZY:
                        begin
                            res_valid        = 1'b1;
                            step_next        = STEP_PTR_HI;
                            res.kind         = KIND_READ;
                            res.read_address = {8'h00, 8'(op_lo_reg + 8'd1)};
                        end
                        MODE_IND:
                        begin
                            res_valid = 1'b1;
                            step_next = STEP_PTR_HI;
                            res.kind  = KIND_READ;
                            // Keep the page-wrap bug: stay in the pointer's page
                            if (op_lo_reg == PTR_LAST_IN_PAGE)
                            begin
                                res.read_address = {op_hi_reg, op_lo_reg} & PAGE_MASK;
                            end
                            else
                            begin
                                res.read_address = {op_hi_reg, op_lo_reg} + 16'd1;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                STEP_PTR_HI:
                begin
                    case (mode_reg)
                        MODE_IZX:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = {q_item.data, ptr_lo_reg};
                            res.operand_bytes = 2'd1;
                        end
                        MODE_IZY:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = idx_sum;
                            res.operand_bytes = 2'd1;
                            res.page_crossed  = idx_crossed;
                        end
                        MODE_IND:
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_ADDR;
                            res.operand_value = {q_item.data, ptr_lo_reg};
                            res.operand_bytes = 2'd2;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end

        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            out_item_next  = out_item_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            mode_reg      <= MODE_IMP;
            pc_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            op_lo_reg     <= '0;
            op_hi_reg     <= '0;
            ptr_lo_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            mode_reg      <= mode_next;
            pc_reg        <= pc_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            op_lo_reg     <= op_lo_next;
            op_hi_reg     <= op_hi_next;
            ptr_lo_reg    <= ptr_lo_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    a_read_leaves_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_READ) |=> step_reg != STEP_IDLE)
        else $error("read request issued but sequence went idle");

    a_final_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind != KIND_READ) |=> step_reg == STEP_IDLE)
        else $error("final result issued but sequence still busy");

    a_cross_only_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.page_crossed) |-> out_item_reg.kind == KIND_ADDR)
        else $error("page-cross flag on a non-address result");

endmodule

// File: rtl/core/cpu6502_operand_address_resolver.sv
// 6502 operand address resolver.
//
// Input channel (in_valid/in_ready/in_item): a start transfer (cmd clear)
// gives the addressing mode, the operand PC and X/Y; every later transfer
// with cmd set returns the byte for the last read request issued.
// Output channel (out_valid/out_ready/out_item): one result per input
// transfer, either a read request or the final value/address with operand
// length and page-cross flag. A stray byte while idle yields nothing.
// Path: each input transfer is registered in the classification queue, and
// its result is registered in the resolver's output register.
// Throughput: one transfer per cycle while the receiver takes each result;
// the two-entry queue between the front and back parts lets the input keep
// accepting while a result waits.
// Receiver stall: the output register holds its result, the queue fills,
// and in_ready drops once both queue entries are in use.
// Reset (rst_n, asynchronous, active low): queue empty, resolver idle,
// no result pending.
module cpu6502_operand_address_resolver import oar_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    logic  q_ready;
    logic  q_push;
    item_t q_push_item;
    logic  q_valid;
    logic  q_pop;
    item_t q_head;

    // Front: accept and classify
    oar_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    // Decoupling queue
    oar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .ready     (q_ready),
        .valid     (q_valid),
        .pop       (q_pop),
        .head      (q_head)
    );

    // Back: step the addressing sequence and hold the result
    oar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
